// ===== hdl/lmsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the pixel-to-pin map of the LED matrix scan driver.
// Used by lmsd_scan_timer and led_matrix_scan_driver_unit.
package lmsd_pkg;

	localparam int unsigned PIX_DIM     = 5;
	localparam int unsigned ROW_COUNT   = 3;
	localparam int unsigned COL_COUNT   = 9;
	localparam int unsigned ROW_W       = 2;
	localparam int unsigned COL_IDX_W   = 4;
	localparam int unsigned COORD_W     = 3;
	localparam int unsigned TICK_W      = 16;
	localparam logic [TICK_W-1:0] SCAN_TICKS_RST = 16'd1000;
	localparam logic [ROW_W-1:0]  LAST_ROW       = 2'd2;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_CLS   = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef logic [COL_COUNT-1:0] row_img_t;
	typedef logic [ROW_W-1:0]     row_idx_t;
	typedef logic [COORD_W-1:0]   coord_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COL_IDX_W-1:0] col;
	} led_pos_t;

	localparam led_pos_t PIX_MAP [0:PIX_DIM-1][0:PIX_DIM-1] = '{
		'{'{2'd0, 4'd0}, '{2'd1, 4'd3}, '{2'd0, 4'd1}, '{2'd1, 4'd4}, '{2'd0, 4'd2}},
		'{'{2'd2, 4'd3}, '{2'd2, 4'd4}, '{2'd2, 4'd5}, '{2'd2, 4'd6}, '{2'd2, 4'd7}},
		'{'{2'd1, 4'd1}, '{2'd0, 4'd8}, '{2'd1, 4'd2}, '{2'd2, 4'd8}, '{2'd1, 4'd0}},
		'{'{2'd0, 4'd7}, '{2'd0, 4'd6}, '{2'd0, 4'd5}, '{2'd0, 4'd4}, '{2'd0, 4'd3}},
		'{'{2'd2, 4'd2}, '{2'd1, 4'd6}, '{2'd2, 4'd0}, '{2'd1, 4'd5}, '{2'd2, 4'd1}}
	};

endpackage

// ===== hdl/lmsd_scan_timer.sv =====
`timescale 1ns / 1ps
// Dwell counter and active row stepper of the LED matrix scan driver.
// Depends on lmsd_pkg.
module lmsd_scan_timer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         tick,
	input  logic [lmsd_pkg::TICK_W-1:0]  scan_ticks,
	output lmsd_pkg::row_idx_t           row_next
);
	import lmsd_pkg::*;

	logic [TICK_W-1:0] dwell_q;
	row_idx_t          row_q;
	logic [TICK_W:0]   dwell_inc;
	logic              wrap;
	logic [TICK_W-1:0] dwell_next;

	assign dwell_inc = {1'b0, dwell_q} + {{TICK_W{1'b0}}, 1'b1};
	assign wrap      = dwell_inc >= {1'b0, scan_ticks};

	always_comb begin
		row_next   = row_q;
		dwell_next = dwell_q;
		if (tick) begin
			if (wrap) begin
				dwell_next = '0;
				row_next   = (row_q >= LAST_ROW) ? '0 : row_q + row_idx_t'(1);
			end else begin
				dwell_next = dwell_inc[TICK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= '0;
			row_q   <= '0;
		end else if (advance) begin
			dwell_q <= dwell_next;
			row_q   <= row_next;
		end
	end

endmodule

// ===== hdl/led_matrix_scan_driver_unit.sv =====
`timescale 1ns / 1ps
// LED matrix scan driver: 5x5 pixels on 3 rows by 9 columns, one pin word per input word.
// Words pass the input and output registers; one word per cycle while out_stall is low.
// Input register, then one pass of pixel update and scan step into the output register.
// Reset clears the screen, the scan row and the dwell count; scan_ticks resets to 1000.
// Depends on lmsd_pkg and lmsd_scan_timer.
module led_matrix_scan_driver_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lmsd_pkg::TICK_W-1:0]           scan_ticks,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  lmsd_pkg::op_t                         operation,
	input  lmsd_pkg::coord_t                      pixel_x,
	input  lmsd_pkg::coord_t                      pixel_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lmsd_pkg::ROW_COUNT-1:0]        row_lines,
	output logic [lmsd_pkg::COL_COUNT-1:0]        column_lines,
	output lmsd_pkg::row_idx_t                    active_row
);
	import lmsd_pkg::*;

	logic [TICK_W-1:0] scan_ticks_q;
	logic              valid_s1;
	op_t               op_s1;
	coord_t            x_s1;
	coord_t            y_s1;
	logic              move;
	row_img_t          img_q [ROW_COUNT];
	row_img_t          img_next [ROW_COUNT];
	row_idx_t          row_next;
	led_pos_t          pos;
	logic              in_range;
	row_img_t          bit_mask;
	row_img_t          cols_on;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ticks_q <= SCAN_TICKS_RST;
		end else if (cfg_valid) begin
			scan_ticks_q <= scan_ticks;
		end
	end

	assign move     = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			x_s1  <= pixel_x;
			y_s1  <= pixel_y;
		end
	end

	assign in_range = (x_s1 < COORD_W'(PIX_DIM)) && (y_s1 < COORD_W'(PIX_DIM));

	always_comb begin
		pos = '0;
		if (in_range) begin
			pos = PIX_MAP[x_s1][y_s1];
		end
	end

	assign bit_mask = row_img_t'(1) << pos.col;

	always_comb begin
		for (int r = 0; r < ROW_COUNT; r++) begin
			img_next[r] = img_q[r];
			case (op_s1)
				OP_SET: begin
					if (in_range && pos.row == ROW_W'(r)) begin
						img_next[r] = img_q[r] | bit_mask;
					end
				end
				OP_CLEAR: begin
					if (in_range && pos.row == ROW_W'(r)) begin
						img_next[r] = img_q[r] & ~bit_mask;
					end
				end
				OP_CLS: begin
					img_next[r] = '0;
				end
				default: begin
					img_next[r] = img_q[r];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				img_q[r] <= '0;
			end
		end else if (move) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				img_q[r] <= img_next[r];
			end
		end
	end

	lmsd_scan_timer u_scan_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (move),
		.tick       (op_s1 == OP_TICK),
		.scan_ticks (scan_ticks_q),
		.row_next   (row_next)
	);

	always_comb begin
		case (row_next)
			2'd0:    cols_on = img_next[0];
			2'd1:    cols_on = img_next[1];
			2'd2:    cols_on = img_next[2];
			default: cols_on = img_next[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!(out_valid && out_stall)) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			row_lines    <= ROW_COUNT'(1) << row_next;
			column_lines <= ~cols_on;
			active_row   <= row_next;
		end
	end

endmodule

// ===== bench/led_matrix_scan_driver_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for led_matrix_scan_driver_unit: drives set, clear, clear-screen and tick words,
// predicts the row and column pin levels per word and checks every output word in order.
// Depends on lmsd_pkg and the RTL of led_matrix_scan_driver_unit.
module led_matrix_scan_driver_unit_test;
	import lmsd_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_WORDS = 181;

	typedef struct packed {
		logic [ROW_COUNT-1:0] row_lines;
		row_img_t             column_lines;
		row_idx_t             active_row;
	} pin_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TICK_W-1:0] scan_ticks = SCAN_TICKS_RST;
	logic              in_valid = 1'b0;
	logic              in_stall;
	op_t               operation = OP_SET;
	coord_t            pixel_x = '0;
	coord_t            pixel_y = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ROW_COUNT-1:0] row_lines;
	row_img_t          column_lines;
	row_idx_t          active_row;

	row_img_t          lit_cols [0:ROW_COUNT-1];
	row_idx_t          shown_row;
	logic [TICK_W-1:0] dwell_ticks;
	logic [TICK_W-1:0] row_period;
	pin_word_t         pins_due [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;

	led_matrix_scan_driver_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.scan_ticks(scan_ticks),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_lines(row_lines),
		.column_lines(column_lines),
		.active_row(active_row)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic report_mismatch(string field, int unsigned got, int unsigned want);
		if (fail_count < 50) begin
			$display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $realtime);
		end
		fail_count++;
	endtask

	function automatic void reset_pin_state();
		for (int r = 0; r < ROW_COUNT; r++) begin
			lit_cols[r] = '0;
		end
		shown_row = '0;
		dwell_ticks = '0;
		row_period = SCAN_TICKS_RST;
	endfunction

	function automatic void predict_pins(op_t op, coord_t x, coord_t y);
		led_pos_t         pos;
		logic [TICK_W:0]  next_dwell;
		pin_word_t        pins;
		case (op)
			OP_SET, OP_CLEAR: begin
				if (x < COORD_W'(PIX_DIM) && y < COORD_W'(PIX_DIM)) begin
					pos = PIX_MAP[x][y];
					lit_cols[pos.row][pos.col] = (op == OP_SET);
				end
			end
			OP_CLS: begin
				for (int r = 0; r < ROW_COUNT; r++) begin
					lit_cols[r] = '0;
				end
			end
			default: begin
				next_dwell = {1'b0, dwell_ticks} + (TICK_W+1)'(1);
				if (next_dwell >= {1'b0, row_period}) begin
					dwell_ticks = '0;
					shown_row = (shown_row == LAST_ROW) ? row_idx_t'(0)
					                                    : shown_row + row_idx_t'(1);
				end else begin
					dwell_ticks = next_dwell[TICK_W-1:0];
				end
			end
		endcase
		pins.row_lines = 3'b001 << shown_row;
		pins.column_lines = ~lit_cols[shown_row];
		pins.active_row = shown_row;
		pins_due.push_back(pins);
	endfunction

	always @(posedge clk) begin : check_pins
		pin_word_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pins_due.size() == 0) begin
				report_mismatch("unexpected word",
				                32'({row_lines, column_lines, active_row}), 0);
			end else begin
				want = pins_due.pop_front();
				if (row_lines !== want.row_lines)
					report_mismatch("row_lines", 32'(row_lines), 32'(want.row_lines));
				if (column_lines !== want.column_lines)
					report_mismatch("column_lines", 32'(column_lines),
					                32'(want.column_lines));
				if (active_row !== want.active_row)
					report_mismatch("active_row", 32'(active_row), 32'(want.active_row));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			    (out_valid === 1'b1 && out_stall === 1'b0) ||
			    (cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL led_matrix_scan_driver_unit");
		$finish;
	end

	task automatic send_word(op_t op, coord_t x, coord_t y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		predict_pins(op, x, y);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pins_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_scan_ticks(logic [TICK_W-1:0] value);
		cfg_valid <= 1'b1;
		scan_ticks <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		row_period = value;
	endtask

	task automatic test_pixel_edges();
		write_scan_ticks(16'd1);
		send_word(OP_SET, 3'd0, 3'd0);
		send_word(OP_SET, 3'd0, 3'd4);
		send_word(OP_SET, 3'd4, 3'd0);
		send_word(OP_SET, 3'd4, 3'd4);
		send_word(OP_SET, 3'd2, 3'd3);
		send_word(OP_SET, 3'd5, 3'd0);
		send_word(OP_SET, 3'd0, 3'd7);
		send_word(OP_CLEAR, 3'd0, 3'd0);
		send_word(OP_CLEAR, 3'd7, 3'd3);
		send_word(OP_TICK, 3'd0, 3'd0);
		send_word(OP_TICK, 3'd7, 3'd7);
		send_word(OP_TICK, 3'd2, 3'd5);
		send_word(OP_CLS, 3'd7, 3'd7);
		send_word(OP_TICK, 3'd3, 3'd1);
	endtask

	task automatic test_zero_ticks();
		wait_drained();
		write_scan_ticks(16'd0);
		send_word(OP_SET, 3'd1, 3'd2);
		send_word(OP_TICK, 3'd0, 3'd0);
		send_word(OP_TICK, 3'd0, 3'd0);
		send_word(OP_TICK, 3'd0, 3'd0);
	endtask

	task automatic test_lowered_dwell();
		wait_drained();
		write_scan_ticks(16'd65535);
		send_word(OP_SET, 3'd3, 3'd3);
		repeat (5) send_word(OP_TICK, 3'd0, 3'd0);
		wait_drained();
		write_scan_ticks(16'd4);
		send_word(OP_TICK, 3'd0, 3'd0);
		send_word(OP_TICK, 3'd0, 3'd0);
	endtask

	task automatic test_random_traffic();
		logic [TICK_W-1:0] periods [0:7];
		int                r;
		coord_t            x;
		coord_t            y;
		op_t               op;
		periods[0] = 16'd1;
		periods[1] = 16'd2;
		periods[2] = 16'd3;
		periods[3] = 16'd65535;
		periods[4] = 16'd0;
		periods[5] = SCAN_TICKS_RST;
		periods[6] = 16'($urandom_range(1, 6));
		periods[7] = 16'($urandom_range(4, 20));
		for (int k = 0; k < 8; k++) begin
			wait_drained();
			write_scan_ticks(periods[k]);
			case (k % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 85; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 85; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			for (int n = 0; n < RANDOM_WORDS; n++) begin
				r = $urandom_range(0, 99);
				op = (r < 35) ? OP_SET : (r < 60) ? OP_CLEAR : (r < 65) ? OP_CLS : OP_TICK;
				x = ($urandom_range(0, 9) == 0) ? coord_t'($urandom_range(0, 7))
				                                : coord_t'($urandom_range(0, 4));
				y = ($urandom_range(0, 9) == 0) ? coord_t'($urandom_range(0, 7))
				                                : coord_t'($urandom_range(0, 4));
				send_word(op, x, y);
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		reset_pin_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_edges();
		test_zero_ticks();
		test_lowered_dwell();
		test_random_traffic();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS led_matrix_scan_driver_unit");
		else
			$display("FAIL led_matrix_scan_driver_unit");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lmsd_pkg.sv
hdl/lmsd_scan_timer.sv
hdl/led_matrix_scan_driver_unit.sv
bench/led_matrix_scan_driver_unit_test.sv
